// ----- sv/crsf_pkg.sv -----
// Shared types, constants and the CRC-8 step function for the CRSF RC frame receiver.
// No dependencies; every other file refers to this package by scoped names.
package crsf_pkg;

	// Frame collection
	localparam int FRAME_MAX   = 64;
	localparam int IDX_W       = $clog2(FRAME_MAX + 1);
	localparam int CMP_W       = (IDX_W > 8) ? IDX_W : 8;
	localparam int LEN_ADJ     = 2;
	localparam int MIN_LEN     = 4;
	localparam logic [7:0] CRC_POLY = 8'hD5;

	// Channel payload: sixteen 11-bit values packed little endian from byte 3
	localparam int NUM_CHAN    = 16;
	localparam int CHAN_W      = 11;
	localparam int CHAN_IDX_W  = $clog2(NUM_CHAN);
	localparam int CHAN_FIRST  = 3;
	localparam int PAYLOAD_W   = NUM_CHAN * CHAN_W;
	localparam int PAYLOAD_B   = PAYLOAD_W / 8;
	localparam int STORE_DEPTH = CHAN_FIRST + PAYLOAD_B;

	// Link timer
	localparam int MS_W = 17;
	localparam logic [MS_W-1:0] MS_MAX = '1;

	// Job queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;
	localparam logic [7:0]  SYNC_RST    = 8'd200;
	localparam logic [7:0]  TYPE_RST    = 8'd22;

	typedef enum logic [1:0] {
		REG_TIMEOUT = 2'd0,
		REG_SYNC    = 2'd1,
		REG_TYPE    = 2'd2
	} reg_idx_t;

	typedef enum logic {
		KIND_CHAN = 1'b0,
		KIND_LOST = 1'b1
	} kind_t;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  sync_value;
		logic [7:0]  rc_frame_type;
	} cfg_t;

	typedef struct packed {
		kind_t                kind;
		logic [PAYLOAD_W-1:0] payload;
	} job_t;

	// One byte through the CRC-8 register, MSB first
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ----- sv/crsf_front.sv -----
// Front end: collects bytes into the frame store, runs CRC and length checks,
// tracks link state and the millisecond timer, and issues jobs. Uses crsf_pkg.
module crsf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                req_type,
	input  logic [7:0]          rx_byte,
	input  crsf_pkg::cfg_t      cfg,
	output logic                job_valid,
	output crsf_pkg::job_t      job
);

	logic [7:0]                     store_q [crsf_pkg::STORE_DEPTH];
	logic [7:0]                     store_nx [crsf_pkg::STORE_DEPTH];
	logic [crsf_pkg::IDX_W-1:0]     idx_q;
	logic [7:0]                     crc_q;
	logic                           link_q;
	logic [crsf_pkg::MS_W-1:0]      ms_q;

	logic [crsf_pkg::IDX_W-1:0]     pos;
	logic [crsf_pkg::IDX_W-1:0]     new_idx;
	logic [7:0]                     crc_cur;
	logic [7:0]                     expected;
	logic                           complete;
	logic                           frame_ok;
	logic [crsf_pkg::MS_W-1:0]      ms_inc;
	logic                           byte_in;
	logic                           tick_in;

	assign byte_in = in_valid && !req_type;
	assign tick_in = in_valid && req_type;

	// Resolve write position: sync byte mid-frame restarts at zero
	assign pos = (rx_byte == cfg.sync_value && idx_q != '0) ? '0 : idx_q;
	assign new_idx = pos + crsf_pkg::IDX_W'(1);

	// Store as seen after this byte lands
	always_comb begin
		for (int i = 0; i < crsf_pkg::STORE_DEPTH; i++) begin
			store_nx[i] = (pos == crsf_pkg::IDX_W'(i)) ? rx_byte : store_q[i];
		end
	end

	// Frame checks
	assign crc_cur  = (pos == crsf_pkg::IDX_W'(1)) ? 8'd0 : crc_q;
	assign expected = store_nx[1] + 8'(crsf_pkg::LEN_ADJ);
	assign complete = (pos != '0) &&
		(crsf_pkg::CMP_W'(new_idx) >= crsf_pkg::CMP_W'(expected));
	assign frame_ok = (expected >= 8'(crsf_pkg::MIN_LEN)) &&
		(store_nx[0] == cfg.sync_value) && (crc_cur == rx_byte) &&
		(store_nx[2] == cfg.rc_frame_type);

	// Saturating tick count
	assign ms_inc = (ms_q == crsf_pkg::MS_MAX) ? ms_q : ms_q + crsf_pkg::MS_W'(1);

	// Issue a job for a good RC frame or for a link timeout
	always_comb begin
		job_valid    = 1'b0;
		job.kind     = crsf_pkg::KIND_CHAN;
		job.payload  = '0;
		if (byte_in && complete && frame_ok) begin
			job_valid = 1'b1;
			for (int j = 0; j < crsf_pkg::PAYLOAD_B; j++) begin
				job.payload[8*j +: 8] = store_nx[crsf_pkg::CHAN_FIRST + j];
			end
		end else if (tick_in && link_q &&
			(ms_inc > crsf_pkg::MS_W'(cfg.timeout_ms))) begin
			job_valid = 1'b1;
			job.kind  = crsf_pkg::KIND_LOST;
		end
	end

	// Advance frame, CRC and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < crsf_pkg::STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
			idx_q  <= '0;
			crc_q  <= '0;
			link_q <= 1'b0;
			ms_q   <= '0;
		end else if (byte_in) begin
			store_q <= store_nx;
			if (pos == '0) begin
				idx_q <= crsf_pkg::IDX_W'(1);
				crc_q <= '0;
			end else if (complete) begin
				idx_q <= '0;
				crc_q <= '0;
				if (frame_ok) begin
					link_q <= 1'b1;
					ms_q   <= '0;
				end
			end else if (new_idx >= crsf_pkg::IDX_W'(crsf_pkg::FRAME_MAX)) begin
				idx_q <= '0;
				crc_q <= '0;
			end else begin
				idx_q <= new_idx;
				crc_q <= (pos >= crsf_pkg::IDX_W'(2)) ? crsf_pkg::crc_step(crc_cur, rx_byte)
					: crc_cur;
			end
		end else if (tick_in && link_q) begin
			ms_q <= ms_inc;
			if (ms_inc > crsf_pkg::MS_W'(cfg.timeout_ms)) begin
				link_q <= 1'b0;
			end
		end
	end

	// Link drops only on a tick
	a_drop_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(link_q) |-> $past(tick_in))
		else $error("link dropped without a tick");

	// Good RC frame restarts the timer and raises the link
	a_frame_restarts_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job.kind == crsf_pkg::KIND_CHAN) |=> (ms_q == '0 && link_q))
		else $error("timer not cleared after channel frame");

endmodule

// ----- sv/crsf_jobq.sv -----
// Short job queue between the front end and the channel unpacker.
// Depends on crsf_pkg for the job type and depth.
module crsf_jobq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  crsf_pkg::job_t      wr_job,
	input  logic                rd_en,
	output logic                rd_valid,
	output crsf_pkg::job_t      rd_job,
	output logic                full
);

	crsf_pkg::job_t               mem_q [crsf_pkg::QDEPTH];
	logic [crsf_pkg::QAW-1:0]     wptr_q;
	logic [crsf_pkg::QAW-1:0]     rptr_q;
	logic [crsf_pkg::QCW-1:0]     cnt_q;

	assign full     = (cnt_q == crsf_pkg::QCW'(crsf_pkg::QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_job   = mem_q[rptr_q];

	// Hold entries; payload needs no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == crsf_pkg::QAW'(crsf_pkg::QDEPTH - 1)) ? '0
					: wptr_q + crsf_pkg::QAW'(1);
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == crsf_pkg::QAW'(crsf_pkg::QDEPTH - 1)) ? '0
					: rptr_q + crsf_pkg::QAW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + crsf_pkg::QCW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - crsf_pkg::QCW'(1);
			end
		end
	end

	// No write into a full queue unless the head leaves in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && full) |-> rd_en)
		else $error("job queue overflow");

endmodule

// ----- sv/crsf_back.sv -----
// Back end: unpacks one job into channel results (or one link-lost result)
// into an output register. Depends on crsf_pkg.
module crsf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_valid,
	input  crsf_pkg::job_t                 job,
	output logic                           job_take,
	input  logic                           pop,
	output logic                           empty,
	output logic                           kind,
	output logic [crsf_pkg::CHAN_IDX_W-1:0] channel_index,
	output logic [crsf_pkg::CHAN_W-1:0]    raw_value,
	output logic                           last,
	output logic                           connected
);

	logic                                busy_q;
	crsf_pkg::kind_t                     kind_q;
	logic [crsf_pkg::PAYLOAD_W-1:0]      data_q;
	logic [crsf_pkg::CHAN_IDX_W-1:0]     cnt_q;

	logic                                ovalid_q;
	crsf_pkg::kind_t                     okind_q;
	logic [crsf_pkg::CHAN_IDX_W-1:0]     oidx_q;
	logic [crsf_pkg::CHAN_W-1:0]         oval_q;
	logic                                olast_q;

	logic                                adv;
	logic                                emit;
	logic                                last_elem;

	assign adv       = !ovalid_q || pop;
	assign emit      = busy_q && adv;
	assign last_elem = (kind_q == crsf_pkg::KIND_LOST) ||
		(cnt_q == crsf_pkg::CHAN_IDX_W'(crsf_pkg::NUM_CHAN - 1));
	assign job_take  = job_valid && (!busy_q || (emit && last_elem));

	// Load a job or step through its channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (job_take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (emit && last_elem) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			cnt_q <= cnt_q + crsf_pkg::CHAN_IDX_W'(1);
		end
	end

	// Job payload: shift out one channel per result
	always_ff @(posedge clk) begin
		if (job_take) begin
			kind_q <= job.kind;
			data_q <= job.payload;
		end else if (emit) begin
			data_q <= data_q >> crsf_pkg::CHAN_W;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			okind_q <= kind_q;
			oidx_q  <= (kind_q == crsf_pkg::KIND_LOST) ? '0 : cnt_q;
			oval_q  <= (kind_q == crsf_pkg::KIND_LOST) ? '0 : data_q[crsf_pkg::CHAN_W-1:0];
			olast_q <= last_elem;
		end
	end

	assign empty         = !ovalid_q;
	assign kind          = okind_q;
	assign channel_index = oidx_q;
	assign raw_value     = oval_q;
	assign last          = olast_q;
	assign connected     = (okind_q == crsf_pkg::KIND_CHAN);

	// Link-lost result is a single final result with zero payload
	a_lost_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && okind_q == crsf_pkg::KIND_LOST) |-> (olast_q && oidx_q == '0 && oval_q == '0))
		else $error("malformed link-lost result");

	// Channel run ends exactly at the final channel
	a_chan_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && okind_q == crsf_pkg::KIND_CHAN) |->
		(olast_q == (oidx_q == crsf_pkg::CHAN_IDX_W'(crsf_pkg::NUM_CHAN - 1))))
		else $error("last flag out of place in channel run");

endmodule

// ----- sv/crsf_rc_frame_receiver.sv -----
// CRSF RC frame receiver top level: APB registers, front end, job queue, back end.
// Depends on crsf_pkg, crsf_front, crsf_jobq and crsf_back.
// Path: a frame's last byte writes a job into the queue, the back end loads it, then its first result is registered.
// Throughput: one input item per cycle while the two-entry job queue has room;
// one result per cycle while results are popped, so a good RC frame drains its 16 channels back to back.
// Reset (arst_n low): clears frame store, link state, timer, queue; registers take defaults.
module crsf_rc_frame_receiver (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input items
	input  logic                            push,
	output logic                            full,
	input  logic                            req_type,
	input  logic [7:0]                      rx_byte,
	// Results
	output logic                            empty,
	input  logic                            pop,
	output logic                            kind,
	output logic [crsf_pkg::CHAN_IDX_W-1:0] channel_index,
	output logic [crsf_pkg::CHAN_W-1:0]     raw_value,
	output logic                            last,
	output logic                            connected,
	// Configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [crsf_pkg::APB_AW-1:0]     paddr,
	input  logic [crsf_pkg::APB_DW-1:0]     pwdata,
	output logic [crsf_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	crsf_pkg::cfg_t   cfg_q;
	crsf_pkg::reg_idx_t reg_idx;
	logic             cfg_wr;
	logic             in_valid;
	logic             fj_valid;
	crsf_pkg::job_t   fj;
	logic             q_valid;
	crsf_pkg::job_t   q_job;
	logic             q_take;

	assign pready  = 1'b1;
	assign reg_idx = crsf_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms    <= crsf_pkg::TIMEOUT_RST;
			cfg_q.sync_value    <= crsf_pkg::SYNC_RST;
			cfg_q.rc_frame_type <= crsf_pkg::TYPE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				crsf_pkg::REG_TIMEOUT: cfg_q.timeout_ms    <= pwdata[15:0];
				crsf_pkg::REG_SYNC:    cfg_q.sync_value    <= pwdata[7:0];
				crsf_pkg::REG_TYPE:    cfg_q.rc_frame_type <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			crsf_pkg::REG_TIMEOUT: prdata = crsf_pkg::APB_DW'(cfg_q.timeout_ms);
			crsf_pkg::REG_SYNC:    prdata = crsf_pkg::APB_DW'(cfg_q.sync_value);
			crsf_pkg::REG_TYPE:    prdata = crsf_pkg::APB_DW'(cfg_q.rc_frame_type);
			default:               prdata = '0;
		endcase
	end

	assign in_valid = push && !full;

	crsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.job_valid (fj_valid),
		.job       (fj)
	);

	crsf_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fj_valid),
		.wr_job   (fj),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_job   (q_job),
		.full     (full)
	);

	crsf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (q_valid),
		.job           (q_job),
		.job_take      (q_take),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.channel_index (channel_index),
		.raw_value     (raw_value),
		.last          (last),
		.connected     (connected)
	);

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for crsf_rc_frame_receiver: byte and tick requests in, channel results out.
// Depends on crsf_pkg and the receiver RTL; a scoreboard class predicts and checks every result.
`timescale 1ns / 1ps

typedef struct {
	crsf_pkg::kind_t kind;
	bit [3:0]        chan;
	bit [10:0]       value;
	bit              last;
	bit              conn;
} chan_result_t;

// CRC-8, polynomial 0xD5, one byte MSB first
function automatic bit [7:0] crc8_d5(bit [7:0] acc, bit [7:0] data);
	bit [7:0] r;
	bit fb;
	r = acc ^ data;
	repeat (8) begin
		fb = r[7];
		r = r << 1;
		if (fb) begin
			r = r ^ 8'hD5;
		end
	end
	return r;
endfunction

class channel_scoreboard;
	// Register copies
	bit [15:0] timeout_ms;
	bit [7:0]  sync_val;
	bit [7:0]  rc_type;
	// Receiver state
	bit [7:0]  frame_bytes[crsf_pkg::FRAME_MAX];
	int        wr_pos;
	bit [7:0]  crc_acc;
	bit        link_up;
	bit [16:0] ms_count;
	chan_result_t pending[$];
	int errors, checked, requests, rc_frames, link_drops;

	function void reset_state();
		timeout_ms = 16'd1000;
		sync_val   = 8'd200;
		rc_type    = 8'd22;
		foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
		wr_pos   = 0;
		crc_acc  = 8'h00;
		link_up  = 1'b0;
		ms_count = '0;
		pending.delete();
	endfunction

	function void set_config(crsf_pkg::reg_idx_t idx, bit [31:0] v);
		case (idx)
			crsf_pkg::REG_TIMEOUT: timeout_ms = v[15:0];
			crsf_pkg::REG_SYNC:    sync_val   = v[7:0];
			crsf_pkg::REG_TYPE:    rc_type    = v[7:0];
			default: ;
		endcase
	endfunction

	task report(string msg);
		errors++;
		$display("tb: mismatch: %s", msg);
	endtask

	// Unpack sixteen 11-bit channels, little endian from byte 3
	function void emit_channels();
		int bitpos, p;
		bit [23:0] w;
		chan_result_t r;
		for (int k = 0; k < crsf_pkg::NUM_CHAN; k++) begin
			bitpos  = crsf_pkg::CHAN_W * k;
			p       = 3 + bitpos / 8;
			w       = {frame_bytes[p + 2], frame_bytes[p + 1], frame_bytes[p]};
			r.kind  = crsf_pkg::KIND_CHAN;
			r.chan  = 4'(k);
			r.value = 11'(w >> (bitpos % 8));
			r.last  = (k == crsf_pkg::NUM_CHAN - 1);
			r.conn  = 1'b1;
			pending.push_back(r);
		end
	endfunction

	// Advance the receiver by one accepted request
	function void note_request(bit is_tick, bit [7:0] data);
		int pos;
		bit [7:0] frame_len;
		bit good;
		requests++;
		if (is_tick) begin
			if (!link_up) return;
			if (ms_count != '1) ms_count++;
			if (ms_count > timeout_ms) begin
				link_up = 1'b0;
				link_drops++;
				pending.push_back('{kind: crsf_pkg::KIND_LOST, chan: 4'd0, value: 11'd0,
					last: 1'b1, conn: 1'b0});
			end
			return;
		end
		// Restart on sync inside a frame, then store
		if (data == sync_val && wr_pos > 0) wr_pos = 0;
		pos = wr_pos;
		frame_bytes[pos] = data;
		wr_pos = pos + 1;
		if (wr_pos < 2) begin
			crc_acc = 8'h00;
			return;
		end
		if (pos == 1) crc_acc = 8'h00;
		frame_len = frame_bytes[1] + 8'd2;
		if (wr_pos >= frame_len) begin
			good = frame_len >= 4 && frame_bytes[0] == sync_val && crc_acc == data;
			if (good && frame_bytes[2] == rc_type) begin
				emit_channels();
				link_up  = 1'b1;
				ms_count = '0;
				rc_frames++;
			end
			wr_pos  = 0;
			crc_acc = 8'h00;
		end else if (pos >= 2 && pos + 1 < frame_len) begin
			crc_acc = crc8_d5(crc_acc, data);
		end
		// Drop an overlong frame
		if (wr_pos >= crsf_pkg::FRAME_MAX) begin
			wr_pos  = 0;
			crc_acc = 8'h00;
		end
	endfunction

	task check_result(crsf_pkg::kind_t k, bit [3:0] chan, bit [10:0] value, bit lst, bit conn);
		chan_result_t e;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result kind %0d chan %0d value %0d", k, chan, value));
			return;
		end
		e = pending.pop_front();
		if (k != e.kind)
			report($sformatf("result %0d: kind %0d, expected %0d", checked, k, e.kind));
		if (chan != e.chan)
			report($sformatf("result %0d: channel %0d, expected %0d", checked, chan, e.chan));
		if (value != e.value)
			report($sformatf("result %0d: value %0d, expected %0d", checked, value, e.value));
		if (lst != e.last)
			report($sformatf("result %0d: last %0d, expected %0d", checked, lst, e.last));
		if (conn != e.conn)
			report($sformatf("result %0d: connected %0d, expected %0d", checked, conn, e.conn));
		checked++;
	endtask

	task check_leftover();
		if (pending.size() != 0)
			report($sformatf("%0d results never arrived", pending.size()));
	endtask
endclass

module tb;

	localparam bit REQ_BYTE = 1'b0;
	localparam bit REQ_TICK = 1'b1;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 500;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {FR_GOOD, FR_BAD_CRC, FR_TRUNC} frame_mode_t;
	typedef bit [8:0] request_t;  // {tick, byte}

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        req_type;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic        kind;
	logic [crsf_pkg::CHAN_IDX_W-1:0] channel_index;
	logic [crsf_pkg::CHAN_W-1:0]     raw_value;
	logic        last;
	logic        connected;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [crsf_pkg::APB_AW-1:0] paddr;
	logic [crsf_pkg::APB_DW-1:0] pwdata;
	logic [crsf_pkg::APB_DW-1:0] prdata;
	logic        pready;

	channel_scoreboard sb;
	request_t    tx_q[$];
	bit          no_gaps;
	bit          rx_eager;
	bit          hold_rx;
	int          idle_cycles = 0;
	int          stall_cycles = 0;

	crsf_rc_frame_receiver u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.channel_index (channel_index),
		.raw_value     (raw_value),
		.last          (last),
		.connected     (connected),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Mostly short gaps, a few long ones
	function automatic int pick_gap(bit eager);
		int r;
		if (eager) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit [7:0] rand_payload();
		bit [7:0] b;
		do begin
			case ($urandom_range(0, 3))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
		end while (b == sb.sync_val);
		return b;
	endfunction

	function automatic bit [7:0] other_type();
		bit [7:0] y;
		do y = 8'($urandom); while (y == sb.rc_type || y == sb.sync_val);
		return y;
	endfunction

	// Append one frame: sync, length, type, payload, CRC (CRC corrupted or tail cut by mode)
	function automatic void build_frame(bit [7:0] ftype, int plen, frame_mode_t mode);
		bit [7:0] body[$];
		bit [7:0] crc;
		int tries, cut;
		tries = 0;
		do begin
			body.delete();
			body.push_back(ftype);
			for (int i = 0; i < plen; i++) body.push_back(rand_payload());
			crc = 8'h00;
			foreach (body[i]) crc = crc8_d5(crc, body[i]);
			tries++;
		end while (crc == sb.sync_val && tries < 20);
		if (mode == FR_BAD_CRC) crc = crc ^ (8'h01 << $urandom_range(0, 7));
		body.push_back(crc);
		cut = (mode == FR_TRUNC) ? $urandom_range(1, plen + 2) : 0;
		tx_q.push_back({REQ_BYTE, sb.sync_val});
		tx_q.push_back({REQ_BYTE, 8'(plen + 2)});
		for (int i = 0; i < body.size() - cut; i++) tx_q.push_back({REQ_BYTE, body[i]});
	endfunction

	// Frame that runs past the end of the store
	function automatic void build_overflow();
		tx_q.push_back({REQ_BYTE, sb.sync_val});
		tx_q.push_back({REQ_BYTE, 8'h60});
		repeat (66) tx_q.push_back({REQ_BYTE, rand_payload()});
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(bit is_tick, bit [7:0] data);
		int gap;
		@(negedge clk);
		push     <= 1'b1;
		req_type <= is_tick;
		rx_byte  <= data;
		do @(posedge clk); while (full !== 1'b0);
		sb.note_request(is_tick, data);
		gap = pick_gap(no_gaps);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_queue();
		foreach (tx_q[i]) send_request(tx_q[i][8], tx_q[i][7:0]);
		tx_q.delete();
	endtask

	task automatic stop_push();
		@(negedge clk);
		push <= 1'b0;
	endtask

	// Wait for every expected result, then let trailing requests settle
	task automatic wait_idle();
		stop_push();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_check(crsf_pkg::reg_idx_t idx, bit [31:0] want);
		bit [31:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd != want)
			sb.report($sformatf("register %s reads %0d, expected %0d", idx.name(), rd, want));
	endtask

	task automatic apb_write(crsf_pkg::reg_idx_t idx, bit [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_config(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apb_check(idx, data);
	endtask

	task automatic write_config(bit [15:0] t, bit [7:0] s, bit [7:0] y);
		wait_idle();
		apb_write(crsf_pkg::REG_TIMEOUT, {16'd0, t});
		apb_write(crsf_pkg::REG_SYNC, {24'd0, s});
		apb_write(crsf_pkg::REG_TYPE, {24'd0, y});
	endtask

	// Mostly well-formed frames, plus ticks, noise and broken frames
	task automatic random_phase(int n_items);
		int sent, r;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				build_frame(sb.rc_type, 22, FR_GOOD);
			end else if (r < 50) begin
				build_frame(sb.rc_type, $urandom_range(0, 21), FR_GOOD);
			end else if (r < 57) begin
				build_frame(other_type(), $urandom_range(0, 12), FR_GOOD);
			end else if (r < 62) begin
				build_frame(sb.rc_type, $urandom_range(0, 22), FR_BAD_CRC);
			end else if (r < 66) begin
				build_frame(sb.rc_type, $urandom_range(1, 22), FR_TRUNC);
			end else if (r < 84) begin
				repeat ($urandom_range(1, 6)) tx_q.push_back({REQ_TICK, 8'($urandom)});
			end else if (r < 91) begin
				repeat ($urandom_range(1, 5)) tx_q.push_back({REQ_BYTE, 8'($urandom)});
			end else if (r < 98) begin
				tx_q.push_back({REQ_BYTE, sb.sync_val});
				case ($urandom_range(0, 3))
					0: tx_q.push_back({REQ_BYTE, 8'h00});
					1: tx_q.push_back({REQ_BYTE, 8'h01});
					2: tx_q.push_back({REQ_BYTE, 8'hFE});
					default: tx_q.push_back({REQ_BYTE, 8'hFF});
				endcase
			end else begin
				build_overflow();
			end
			sent += tx_q.size();
			send_queue();
		end
	endtask

	// Receiver: random pop gaps, one long hold-off on request
	initial begin : rx_side
		int wait_left;
		wait_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rx = 1'b0;
			end
			if (wait_left > 0) begin
				pop <= 1'b0;
				wait_left--;
			end else begin
				pop <= 1'b1;
				wait_left = pick_gap(rx_eager);
			end
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(crsf_pkg::kind_t'(kind), channel_index, raw_value, last, connected);
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (push && full) stall_cycles <= stall_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		bit [15:0] t3;
		bit [7:0]  s3, y3;
		sb = new();
		sb.reset_state();
		arst_n   = 1'b0;
		push     = 1'b0;
		req_type = 1'b0;
		rx_byte  = 8'h00;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		no_gaps  = 1'b0;
		rx_eager = 1'b0;
		hold_rx  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values, then a short timeout for the directed part
		apb_check(crsf_pkg::REG_TIMEOUT, 32'd1000);
		apb_check(crsf_pkg::REG_SYNC, 32'd200);
		apb_check(crsf_pkg::REG_TYPE, 32'd22);
		write_config(16'd3, 8'd200, 8'd22);

		// Ticks with the link down, then lengths below four and a wrapped length
		repeat (2) tx_q.push_back({REQ_TICK, 8'($urandom)});
		tx_q.push_back({REQ_BYTE, 8'd200});
		tx_q.push_back({REQ_BYTE, 8'h01});
		tx_q.push_back({REQ_BYTE, 8'd200});
		tx_q.push_back({REQ_BYTE, 8'hFF});
		// Short RC frame: channels from stale store bytes
		build_frame(sb.rc_type, 0, FR_GOOD);
		// Valid frame of another type: silent
		build_frame(8'h10, 1, FR_GOOD);
		// Timeout: drop on the fourth tick
		repeat (4) tx_q.push_back({REQ_TICK, 8'($urandom)});
		build_frame(sb.rc_type, 0, FR_BAD_CRC);
		send_queue();

		// Default-like setting with an eager receiver
		rx_eager = 1'b1;
		random_phase(30);
		rx_eager = 1'b0;

		// Low extremes, with one frame overrunning the store
		write_config(16'd1, 8'd0, 8'd255);
		build_overflow();
		send_queue();
		random_phase(10);

		// High extremes; hold off the receiver long enough for the input to stall
		write_config(16'd65535, 8'd255, 8'd0);
		hold_rx = 1'b1;
		no_gaps = 1'b1;
		repeat (4) build_frame(sb.rc_type, 22, FR_GOOD);
		send_queue();
		no_gaps = 1'b0;
		random_phase(10);

		// Random setting
		t3 = 16'($urandom_range(2, 12));
		s3 = 8'($urandom);
		do y3 = 8'($urandom); while (y3 == s3);
		write_config(t3, s3, y3);
		random_phase(30);

		// Back-to-back requests
		write_config(16'd7, 8'd200, 8'd22);
		no_gaps = 1'b1;
		random_phase(30);
		no_gaps = 1'b0;

		wait_idle();
		sb.check_leftover();
		$display("run covered: %0d requests, %0d results checked, %0d RC frames, %0d link drops",
			sb.requests, sb.checked, sb.rc_frames, sb.link_drops);
		$display("run covered: %0d cycles of input stall, %0d mismatches",
			stall_cycles, sb.errors);
		if (sb.errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/crsf_pkg.sv
sv/crsf_front.sv
sv/crsf_jobq.sv
sv/crsf_back.sv
sv/crsf_rc_frame_receiver.sv
sim/tb.sv
